@@ design/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;
    localparam int TAG_BITS = 8;
    localparam int OCC_BITS = $clog2(CAPACITY + 1);

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_POP    = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // Broadcast to every cell of the chain in the cycle a beat is taken.
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry entry;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ design/spq_if.sv @@
// Handshake channels of the sorted priority queue: request and response.
// Depends on spq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if import spq_pkg::*;;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;

    modport source (output valid, output kind, output key, output tag, input ready);
    modport sink   (input valid, input kind, input key, input tag, output ready);
endinterface

interface spq_out_if import spq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic [OCC_BITS-1:0] occupancy;

    modport source (output valid, output status, output out_key, output out_tag,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_key, input out_tag,
                    input occupancy, output ready);
endinterface

`default_nettype wire

@@ design/spq_cell.sv @@
// One slot of the sorted chain: holds a key and a tag, compares against the
// broadcast key and trades its entry with a neighbor. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  logic       i_left_place,
    input  t_entry     i_left_entry,
    input  t_entry     i_right_entry,
    output logic       o_place,
    output t_entry     o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // The new entry belongs here or further up when this slot is free or
    // holds a strictly smaller key, so equal keys stay ahead of it.
    assign o_place = i_ctrl.ins && (!i_occupied || (r_entry.key < i_ctrl.entry.key));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (i_left_place) begin
                n_entry = i_left_entry;
            end else if (o_place) begin
                n_entry = i_ctrl.entry;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

@@ design/sorted_priority_queue.sv @@
// Sorted priority queue: a chain of CAPACITY cells kept in descending key order, slot 0 the
// head. An insert beat places its entry behind all stored entries with a greater or equal key;
// a pop beat returns the head. Every request beat yields one response beat in the next cycle, and
// a new request can be taken every cycle, because all cells compare and shift in parallel in the
// same cycle; a response that waits untaken holds off the next request until it leaves.
// Depends on spq_pkg, spq_if and spq_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_req,
    spq_out_if.source o_rsp
);

    logic [OCC_BITS-1:0] r_count;
    logic [OCC_BITS-1:0] n_count;
    logic                r_out_valid;
    t_status             r_status;
    t_status             n_status;
    t_entry              r_out_entry;
    t_entry              n_out_entry;
    logic [OCC_BITS-1:0] r_occ;

    logic       w_take;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;
    logic       w_place [CAPACITY];
    t_entry     w_entry [CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_take      = i_req.valid && i_req.ready;
    assign w_full      = (r_count == OCC_BITS'(CAPACITY));
    assign w_empty     = (r_count == '0);

    always_comb begin
        w_ctrl.ins       = w_take && (t_kind'(i_req.kind) == KIND_INSERT) && !w_full;
        w_ctrl.pop       = w_take && (t_kind'(i_req.kind) == KIND_POP) && !w_empty;
        w_ctrl.entry.key = i_req.key;
        w_ctrl.entry.tag = i_req.tag;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   w_left_place;
        t_entry w_left_entry;
        t_entry w_right_entry;

        if (g == 0) begin : g_head
            assign w_left_place = 1'b0;
            assign w_left_entry = w_ctrl.entry;
        end else begin : g_body
            assign w_left_place = w_place[g-1];
            assign w_left_entry = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_entry = w_entry[g];
        end else begin : g_inner
            assign w_right_entry = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occupied    (r_count > OCC_BITS'(g)),
            .i_left_place  (w_left_place),
            .i_left_entry  (w_left_entry),
            .i_right_entry (w_right_entry),
            .o_place       (w_place[g]),
            .o_entry       (w_entry[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_status    = ST_DONE;
        n_out_entry = '0;
        if (t_kind'(i_req.kind) == KIND_POP) begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_out_entry = w_entry[0];
                n_count     = r_count - 1'b1;
            end
        end else begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status    <= n_status;
            r_out_entry <= n_out_entry;
            r_occ       <= n_count;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.out_key   = r_out_entry.key;
    assign o_rsp.out_tag   = r_out_entry.tag;
    assign o_rsp.occupancy = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OCC_BITS'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= OCC_BITS'(2)) |-> (w_entry[0].key >= w_entry[1].key))
        else $error("head entry is not the highest key");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FULL)) |-> (r_occ == OCC_BITS'(CAPACITY)))
        else $error("full response without a full queue");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_EMPTY)) |-> (r_occ == '0))
        else $error("empty response with stored entries");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not remove exactly one entry");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking bench for sorted_priority_queue: drives insert and pop beats, mirrors the
// sorted list in a scoreboard class and compares every response beat against it.
// Depends on spq_pkg, spq_if and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    typedef struct {
        t_status             status;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic [OCC_BITS-1:0] occupancy;
    } t_queue_rsp;

    // Keeps its own copy of the stored entries, highest key first, and the responses
    // still owed by the block in the order their requests were taken.
    class queue_scoreboard;
        t_entry      slots[CAPACITY];
        int unsigned stored;
        t_queue_rsp  awaited[$];
        int unsigned checked;
        int unsigned fail_count;

        function new();
            stored     = 0;
            checked    = 0;
            fail_count = 0;
        endfunction

        function t_queue_rsp apply_request(t_kind kind, logic [KEY_BITS-1:0] key,
                                           logic [TAG_BITS-1:0] tag);
            t_queue_rsp  r;
            int unsigned pos;
            int unsigned i;
            r.status = ST_DONE;
            r.key    = '0;
            r.tag    = '0;
            if (kind == KIND_INSERT) begin
                if (stored >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // Equal keys stay ahead, so ties leave in arrival order.
                    pos = 0;
                    while (pos < stored && slots[pos].key >= key)
                        pos++;
                    for (i = stored; i > pos; i--)
                        slots[i] = slots[i-1];
                    slots[pos].key = key;
                    slots[pos].tag = tag;
                    stored++;
                end
            end else if (stored == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.key = slots[0].key;
                r.tag = slots[0].tag;
                for (i = 1; i < stored; i++)
                    slots[i-1] = slots[i];
                stored--;
            end
            r.occupancy = OCC_BITS'(stored);
            return r;
        endfunction

        task note_request(t_kind kind, logic [KEY_BITS-1:0] key, logic [TAG_BITS-1:0] tag);
            awaited.push_back(apply_request(kind, key, tag));
        endtask

        task report_mismatch(string msg);
            $display("MISMATCH at response %0d: %s", checked, msg);
            fail_count++;
        endtask

        task check_response(logic [1:0] status, logic [KEY_BITS-1:0] key,
                            logic [TAG_BITS-1:0] tag, logic [OCC_BITS-1:0] occupancy);
            t_queue_rsp want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected beat status %0d key %h tag %h occ %0d",
                                          status, key, tag, occupancy));
            end else begin
                want = awaited.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (key !== want.key)
                    report_mismatch($sformatf("out_key %h, expected %h", key, want.key));
                if (tag !== want.tag)
                    report_mismatch($sformatf("out_tag %h, expected %h", tag, want.tag));
                if (occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              occupancy, want.occupancy));
            end
            checked++;
        endtask

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    spq_in_if  req_if();
    spq_out_if rsp_if();

    sorted_priority_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    queue_scoreboard board = new();
    int unsigned     send_gap_max;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one request beat after a random gap and waits until it is taken.
    task automatic issue(t_kind kind, logic [KEY_BITS-1:0] key, logic [TAG_BITS-1:0] tag);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind  <= kind;
        req_if.key   <= key;
        req_if.tag   <= tag;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(kind, key, tag);
    endtask

    // Request side: reset, directed beats, then random beats in segments of varying mix.
    initial begin
        int unsigned         n;
        int unsigned         insert_pct;
        int unsigned         key_mode;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;

        send_gap_max = 5;
        req_if.valid <= 1'b0;
        req_if.kind  <= KIND_INSERT;
        req_if.key   <= '0;
        req_if.tag   <= '0;
        i_rst_n      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pop on an empty queue, with nonzero fields that must be ignored.
        issue(KIND_POP, 16'hFFFF, 8'hFF);
        // Fill to capacity with extreme keys and runs of equal keys.
        issue(KIND_INSERT, 16'hFFFF, 8'hFF);
        issue(KIND_INSERT, 16'h0000, 8'h00);
        issue(KIND_INSERT, 16'h8000, 8'h01);
        issue(KIND_INSERT, 16'h8000, 8'h02);
        issue(KIND_INSERT, 16'h8000, 8'h03);
        issue(KIND_INSERT, 16'h0000, 8'h10);
        issue(KIND_INSERT, 16'hFFFF, 8'h20);
        issue(KIND_INSERT, 16'h5555, 8'hAA);
        issue(KIND_INSERT, 16'hAAAA, 8'h55);
        issue(KIND_INSERT, 16'h0001, 8'h80);
        issue(KIND_INSERT, 16'hFFFE, 8'h7F);
        issue(KIND_INSERT, 16'h8000, 8'h04);
        issue(KIND_INSERT, 16'h8000, 8'h05);
        issue(KIND_INSERT, 16'h1234, 8'h0C);
        issue(KIND_INSERT, 16'h7FFF, 8'hFE);
        issue(KIND_INSERT, 16'h8001, 8'h01);
        // The queue is full now, so this one is dropped.
        issue(KIND_INSERT, 16'h9999, 8'h99);
        issue(KIND_POP, 16'h0000, 8'h00);
        issue(KIND_POP, 16'hFFFF, 8'hFF);
        issue(KIND_POP, 16'h0000, 8'h00);
        issue(KIND_POP, 16'hFFFF, 8'hFF);
        issue(KIND_POP, 16'h0000, 8'h00);
        issue(KIND_POP, 16'hFFFF, 8'hFF);

        insert_pct = 50;
        key_mode   = 1;
        for (n = 0; n < 1750; n++) begin
            // A skewed mix drives the queue to full or to empty; a balanced one wanders.
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 15;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
                key_mode     = $urandom_range(0, 2);
            end
            tag = TAG_BITS'($urandom);
            if ($urandom_range(0, 99) < insert_pct) begin
                case (key_mode)
                    0: key = KEY_BITS'($urandom_range(0, 3));
                    1: key = KEY_BITS'($urandom);
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       key = 16'h0000;
                            1:       key = 16'hFFFF;
                            2:       key = 16'h0001;
                            default: key = 16'hFFFE;
                        endcase
                    end
                endcase
                issue(KIND_INSERT, key, tag);
            end else begin
                key = KEY_BITS'($urandom);
                issue(KIND_POP, key, tag);
            end
        end
        req_if.valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Response side: random stalls, stretches without stalls, and two long hold-offs
    // that back the block up until it refuses request beats.
    initial begin
        int unsigned stall;
        int unsigned got;
        int unsigned stall_max;

        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        got       = 0;
        stall_max = 5;
        forever begin
            if (got % 64 == 0)
                stall_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
            if (got == 200 || got == 900)
                stall = 60;
            else
                stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            board.check_response(rsp_if.status, rsp_if.out_key, rsp_if.out_tag,
                                 rsp_if.occupancy);
            got++;
        end
    end

endmodule
